>>> rtl/srsa_pkg.sv
// srsa_pkg: shared types and constants for the strided ring slot allocator
// used by the top level and by its port checker; depends on nothing

package srsa_pkg;

    // slot arithmetic is done at this width: pool sizes up to 2047 plus a word or a stride
    localparam int CW = 12;

    // bitmap word geometry
    localparam int WB = 5;
    localparam int WW = 1 << WB;

    // field widths
    localparam int POOL_W = 11;
    localparam int IDX_W  = 10;

    // the pool size register cannot express more slots than this
    localparam int POOL_CAP = (1 << POOL_W) - 1;

    localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

    // parameter defaults
    localparam int MAX_SLOTS_DEF  = 1024;
    localparam int SCAN_LIMIT_DEF = 128;
    localparam int STRIDE_DEF     = 8;

    // stream and register port widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register index taken from paddr[2]
    localparam logic REG_POOL_SIZE = 1'b0;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    // result item, got_slot in the lowest bit
    typedef struct packed {
        logic             evicted;
        logic [IDX_W-1:0] slot;
        logic             got_slot;
    } t_result;

endpackage

>>> rtl/strided_ring_slot_allocator.sv
// strided_ring_slot_allocator: slot pool kept as a bitmap in one synchronous memory
// depends on srsa_pkg

// Usage
//   slave stream: one item per request. tuser is the op (0 allocate, 1 release),
//   tdata[9:0] is the slot to release. Items are taken one at a time.
//   master stream: one result item per request. tdata[0] got_slot, tdata[10:1] slot,
//   tdata[11] evicted. A result sits in an output register; the next request is
//   accepted while it waits, and its own result waits behind it if the sink stalls.
//   register port: pool_size at byte address 0; writing it restarts the pool.
// Sequence
//   the bitmap is read one 32-slot word per access, through a registered read port.
//   A release, or an allocate whose pointer slot is idle, goes accept, read, evaluate,
//   load output before the next acceptance, and shows its result once it is loaded;
//   a release outside the pool or an allocate on an empty pool skips the read and
//   evaluate steps. An allocate that hits a busy slot adds a read and an evaluate per
//   bitmap word the scan touches: 4 or 5 words for the default scan of 128 slots, one
//   more if it wraps at a pool end inside a word, up to one word per slot for small pools.
// Reset and pool restart
//   after reset, and after every pool_size write, a clearing pass zeroes the bitmap
//   one word per cycle, and lasts longer if the stride has to be reduced modulo a pool
//   smaller than it. No item is accepted during that pass.

module strided_ring_slot_allocator #(
    parameter int MAX_SLOTS  = srsa_pkg::MAX_SLOTS_DEF,
    parameter int SCAN_LIMIT = srsa_pkg::SCAN_LIMIT_DEF,
    parameter int STRIDE     = srsa_pkg::STRIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [srsa_pkg::APB_AW-1:0]   i_paddr,
    input  logic [srsa_pkg::APB_DW-1:0]   i_pwdata,
    output logic [srsa_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [srsa_pkg::S_DATA_W-1:0] i_s_tdata,   // [9:0] slot_index, [15:10] zero
    input  logic [0:0]                    i_s_tuser,   // [0] op
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [srsa_pkg::M_DATA_W-1:0] o_m_tdata    // [0] got_slot, [10:1] slot,
                                                       // [11] evicted, [15:12] zero
);
    import srsa_pkg::*;

    // slots the pool can really hold: limited by storage and by the register width
    localparam int EFF_MAX = (MAX_SLOTS < POOL_CAP) ? MAX_SLOTS : POOL_CAP;
    localparam int NW      = (EFF_MAX + WW - 1) / WW;
    localparam int AW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW      = AW + WB;
    localparam int RW      = $clog2(SCAN_LIMIT + 1);

    localparam logic [CW-1:0] EFF_MAX_C = CW'(EFF_MAX);
    localparam logic [CW-1:0] STRIDE_C  = CW'(STRIDE);
    localparam logic [CW-1:0] WW_C      = CW'(WW);
    localparam logic [RW-1:0] SCAN_C    = RW'(SCAN_LIMIT);
    localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [POOL_W-1:0]   r_pool_size;
    logic [AW-1:0]       r_clr_addr;
    logic                r_clr_done;
    logic [CW-1:0]       r_stride_mod;   // STRIDE mod pool size, reduced during the clearing pass
    logic [PW-1:0]       r_next_free;
    logic [PW-1:0]       r_ptr;          // slot under test, or first slot of the next scan word
    logic [RW-1:0]       r_rem;          // slots left to scan
    logic                r_scan;
    t_op                 r_op;
    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;

    // active bitmap, one word per row
    logic [WW-1:0]       r_mem [NW];
    logic [WW-1:0]       r_rdata;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WW-1:0]       mem_wdata;

    logic                cfg_wr;
    logic                out_load;
    logic [CW-1:0]       pool_c;
    logic [CW-1:0]       size_eff;
    logic                stride_ok;

    logic [WB-1:0]       lo;
    logic [AW-1:0]       wbase;
    logic [CW-1:0]       ptr_c;
    logic [CW-1:0]       to_word_end;
    logic [CW-1:0]       to_pool_end;
    logic [CW-1:0]       rem_c;
    logic [CW-1:0]       consumed;
    logic [CW-1:0]       hi_c;
    logic                found;
    logic [WB-1:0]       f;
    logic [CW-1:0]       taken_c;
    logic [CW-1:0]       after_c;
    logic [CW-1:0]       after_wrap;
    logic [CW-1:0]       step_c;
    logic [CW-1:0]       stride_next;
    logic [CW-1:0]       inc_c;
    logic [CW-1:0]       inc_wrap;
    logic [CW-1:0]       adv_c;
    logic [CW-1:0]       adv_wrap;
    logic                cur_bit;
    logic [WW-1:0]       mask_lo;
    logic [WW-1:0]       mask_f;
    logic [IDX_W-1:0]    req_idx;
    t_op                 req_op;

    // register port
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready &&
                      (i_paddr[2] == REG_POOL_SIZE);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_POOL_SIZE) ? APB_DW'(r_pool_size) : '0;

    // stream ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(r_out);
    assign req_idx    = i_s_tdata[IDX_W-1:0];
    assign req_op     = t_op'(i_s_tuser[0]);

    // finished result moves into the output register once it is free or draining
    assign out_load = (r_state == S_DONE) && !cfg_wr && (!r_out_valid || i_m_tready);

    // pool size above storage acts as the storage size
    assign pool_c    = CW'(r_pool_size);
    assign size_eff  = (pool_c > EFF_MAX_C) ? EFF_MAX_C : pool_c;
    assign stride_ok = (size_eff == '0) || (r_stride_mod < size_eff);

    // word view of the pointer
    assign lo      = r_ptr[WB-1:0];
    assign wbase   = r_ptr[PW-1:WB];
    assign ptr_c   = CW'(r_ptr);
    assign cur_bit = r_rdata[lo];
    assign mask_lo = WW'(1) << lo;
    assign mask_f  = WW'(1) << f;

    // slots scanned in this word: bounded by word end, pool end and scan budget
    always_comb begin
        to_word_end = WW_C - CW'(lo);
        to_pool_end = size_eff - ptr_c;
        rem_c       = CW'(r_rem);
        consumed    = to_word_end;
        if (to_pool_end < consumed) begin
            consumed = to_pool_end;
        end
        if (rem_c < consumed) begin
            consumed = rem_c;
        end
        hi_c = CW'(lo) + consumed;
    end

    // first idle slot inside the scanned window
    always_comb begin
        found = 1'b0;
        f     = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if ((CW'(b) >= CW'(lo)) && (CW'(b) < hi_c) && !r_rdata[b]) begin
                found = 1'b1;
                f     = WB'(b);
            end
        end
    end

    // pointer arithmetic, each a true modulo since every operand stays below the pool size
    always_comb begin
        taken_c     = found ? CW'({wbase, f}) : (ptr_c + consumed - CW'(1));
        after_c     = taken_c + CW'(1);
        after_wrap  = (after_c == size_eff) ? '0 : after_c;
        step_c      = ptr_c + r_stride_mod;
        stride_next = (step_c >= size_eff) ? (step_c - size_eff) : step_c;
        inc_c       = ptr_c + CW'(1);
        inc_wrap    = (inc_c == size_eff) ? '0 : inc_c;
        adv_c       = ptr_c + consumed;
        adv_wrap    = (adv_c == size_eff) ? '0 : adv_c;
    end

    // bitmap write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        case (r_state)
            S_INIT: begin
                mem_we = !r_clr_done;
            end
            S_EVAL: begin
                mem_waddr = wbase;
                if (r_op == OP_RELEASE) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata & ~mask_lo;
                end else if (!r_scan) begin
                    mem_we    = !cur_bit;
                    mem_wdata = r_rdata | mask_lo;
                end else begin
                    // an evicted slot is already set, so only a found slot is written
                    mem_we    = found;
                    mem_wdata = r_rdata | mask_f;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_ptr[PW-1:WB]];
    end

    // sequencer: one item at a time, read then evaluate, repeated per scan word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_pool_size  <= POOL_RESET;
            r_clr_addr   <= '0;
            r_clr_done   <= 1'b0;
            r_stride_mod <= STRIDE_C;
            r_next_free  <= '0;
            r_scan       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                // a pool size write restarts the pool
                r_pool_size  <= i_pwdata[POOL_W-1:0];
                r_state      <= S_INIT;
                r_clr_addr   <= '0;
                r_clr_done   <= 1'b0;
                r_stride_mod <= STRIDE_C;
                r_next_free  <= '0;
            end else begin
                case (r_state)
                    S_INIT: begin
                        if (!r_clr_done) begin
                            r_clr_addr <= r_clr_addr + AW'(1);
                            if (r_clr_addr == LAST_WORD) begin
                                r_clr_done <= 1'b1;
                            end
                        end
                        if (!stride_ok) begin
                            r_stride_mod <= r_stride_mod - size_eff;
                        end
                        if (r_clr_done && stride_ok) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_s_tvalid) begin
                            r_op   <= req_op;
                            r_scan <= 1'b0;
                            if (req_op == OP_RELEASE) begin
                                r_res.got_slot <= 1'b0;
                                r_res.slot     <= req_idx;
                                r_res.evicted  <= 1'b0;
                                if (CW'(req_idx) < size_eff) begin
                                    r_ptr   <= PW'(req_idx);
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else if (size_eff == '0) begin
                                // empty pool: no slot, nothing changes
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end else begin
                                r_ptr   <= r_next_free;
                                r_state <= S_RD;
                            end
                        end
                    end
                    S_RD: begin
                        r_state <= S_EVAL;
                    end
                    S_EVAL: begin
                        if (r_op == OP_RELEASE) begin
                            r_state <= S_DONE;
                        end else if (!r_scan) begin
                            if (!cur_bit) begin
                                r_res.got_slot <= 1'b1;
                                r_res.slot     <= IDX_W'(r_ptr);
                                r_res.evicted  <= 1'b0;
                                r_next_free    <= PW'(stride_next);
                                r_state        <= S_DONE;
                            end else begin
                                // pointer slot busy: scan from the slot after it
                                r_ptr   <= PW'(inc_wrap);
                                r_rem   <= SCAN_C;
                                r_scan  <= 1'b1;
                                r_state <= S_RD;
                            end
                        end else if (found || (consumed == rem_c)) begin
                            r_res.got_slot <= 1'b1;
                            r_res.slot     <= IDX_W'(taken_c);
                            r_res.evicted  <= !found;
                            r_next_free    <= PW'(after_wrap);
                            r_state        <= S_DONE;
                        end else begin
                            r_ptr   <= PW'(adv_wrap);
                            r_rem   <= r_rem - RW'(consumed);
                            r_state <= S_RD;
                        end
                    end
                    S_DONE: begin
                        if (out_load) begin
                            r_out   <= r_res;
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_INIT;
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/srsa_checker.sv
// srsa_checker: port-level assertions for the strided ring slot allocator
// depends on srsa_pkg; bound to strided_ring_slot_allocator below

module srsa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [srsa_pkg::APB_AW-1:0]   i_paddr,
    input  logic [srsa_pkg::APB_DW-1:0]   i_pwdata,
    input  logic [srsa_pkg::APB_DW-1:0]   o_prdata,
    input  logic                          o_pready,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic [srsa_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [srsa_pkg::M_DATA_W-1:0] o_m_tdata
);
    import srsa_pkg::*;

    logic pool_wr;
    logic s_acc;
    t_result res;

    assign pool_wr = i_psel && i_penable && i_pwrite && o_pready &&
                     (i_paddr[2] == REG_POOL_SIZE);
    assign s_acc   = i_s_tvalid && o_s_tready;
    assign res     = t_result'(o_m_tdata[$bits(t_result)-1:0]);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // an eviction only comes with a granted slot
    a_evict_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res.evicted |-> res.got_slot)
        else $error("eviction flagged without a slot");

    // one item in flight: no acceptance right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("item accepted while another is in flight");

    // a pool size write starts the clearing pass
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pool_wr |=> !o_s_tready)
        else $error("ready during clearing pass");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind strided_ring_slot_allocator srsa_checker u_srsa_checker (.*);

>>> dv/strided_ring_slot_allocator_tb.sv
// testbench for strided_ring_slot_allocator: random and directed allocate/release items
// checked against a behavioral slot pool model; depends on srsa_pkg and the rtl top level
`timescale 1ns / 100ps

module strided_ring_slot_allocator_tb;
    import srsa_pkg::*;

    localparam int unsigned SLOT_CAP    = MAX_SLOTS_DEF;
    localparam int unsigned SCAN_DEPTH  = SCAN_LIMIT_DEF;
    localparam int unsigned STRIDE_STEP = STRIDE_DEF;

    // pool_size lives at byte address 0, register index in paddr[2]
    localparam logic [APB_AW-1:0] POOL_SIZE_ADDR = {REG_POOL_SIZE, 2'b00};

    // no handshake for this many cycles means the block is hung
    localparam int unsigned IDLE_LIMIT = 4000;

    // pool sizes of the random phases: extremes, sizes below the stride, oversized,
    // and mid sizes small enough to fill up and force evictions
    localparam int unsigned PHASE_SIZES [13] = '{100, 37, 1024, 129, 1, 64, 2047,
                                                 16, 0, 200, 513, 7, 1023};

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_slot_req;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } t_sink_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                apb_sel;
    logic                apb_en;
    logic                apb_write;
    logic [APB_AW-1:0]   apb_addr;
    logic [APB_DW-1:0]   apb_wdata;
    logic [APB_DW-1:0]   o_prdata;
    logic                o_pready;
    logic                s_valid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                o_m_tvalid;
    logic                m_ready;
    logic [M_DATA_W-1:0] o_m_tdata;

    strided_ring_slot_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (apb_sel),
        .i_penable  (apb_en),
        .i_pwrite   (apb_write),
        .i_paddr    (apb_addr),
        .i_pwdata   (apb_wdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // [9:0] slot_index, [15:10] zero
        .i_s_tuser  (s_tuser),     // [0] op
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)    // [0] got_slot, [10:1] slot, [11] evicted, [15:12] zero
    );

    // model of the pool, updated at every accepted item and every pool_size write
    bit               slot_busy [SLOT_CAP];
    logic [IDX_W-1:0] free_ptr;
    logic [POOL_W-1:0] pool_cfg;

    t_slot_req   pending_slot_ops [$];
    t_result     expected_slot_results [$];

    int unsigned slot_errors;
    int unsigned results_seen;
    int unsigned idle_cycles;
    bit          req_fire;

    // sender burst state
    int unsigned burst_left;
    int unsigned gap_left;

    // receiver stall state
    t_sink_mode  sink_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          held_once;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        apb_sel      = 1'b0;
        apb_en       = 1'b0;
        apb_write    = 1'b0;
        apb_addr     = '0;
        apb_wdata    = '0;
        s_valid      = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_ready      = 1'b0;
        pool_cfg     = POOL_RESET;
        free_ptr     = '0;
        slot_busy    = '{default: 1'b0};
        slot_errors  = 0;
        results_seen = 0;
        idle_cycles  = 0;
        req_fire     = 1'b0;
        burst_left   = 16;
        gap_left     = 0;
        sink_mode    = SINK_OPEN;
        mode_left    = 100;
        hold_left    = 0;
        held_once    = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // works out the result of one item and moves the pool model on
    function automatic t_result predict_slot_result(input t_op op, input logic [IDX_W-1:0] idx);
        t_result     r;
        int unsigned n;
        int unsigned cur;
        int unsigned ptr;
        int unsigned taken;
        int unsigned c;
        bit          evict;
        r = '0;
        n = (pool_cfg > SLOT_CAP) ? SLOT_CAP : pool_cfg;
        if (op == OP_RELEASE) begin
            // out-of-range release only echoes the index
            if (idx < n)
                slot_busy[idx] = 1'b0;
            r.slot = idx;
            return r;
        end
        // empty pool: nothing granted, nothing changes
        if (n == 0)
            return r;
        cur   = free_ptr % n;
        evict = 1'b0;
        if (!slot_busy[cur]) begin
            taken    = cur;
            free_ptr = IDX_W'((cur + STRIDE_STEP) % n);
        end else begin
            // scan from the slot after the pointer; a short pool is walked round again
            ptr   = (cur + 1) % n;
            taken = cur;
            evict = 1'b1;
            for (c = 0; c < SCAN_DEPTH; c++) begin
                taken = ptr;
                ptr   = (ptr + 1) % n;
                if (!slot_busy[taken]) begin
                    evict = 1'b0;
                    break;
                end
            end
            free_ptr = IDX_W'(ptr);
        end
        slot_busy[taken] = 1'b1;
        r.got_slot       = 1'b1;
        r.slot           = taken[IDX_W-1:0];
        r.evicted        = evict;
        return r;
    endfunction

    function automatic void push_request(input t_op op, input logic [IDX_W-1:0] idx);
        t_slot_req r;
        r.op  = op;
        r.idx = idx;
        pending_slot_ops.insert(pending_slot_ops.size(), r);
    endfunction

    // block is quiet: every item sent and every result back
    task automatic wait_idle();
        while (pending_slot_ops.size() != 0 || s_valid || expected_slot_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // setup then access cycle; the write restarts the pool, so the model restarts too
    task automatic write_pool_size(input logic [POOL_W-1:0] value);
        @(negedge i_clk);
        apb_sel   <= 1'b1;
        apb_en    <= 1'b0;
        apb_write <= 1'b1;
        apb_addr  <= POOL_SIZE_ADDR;
        apb_wdata <= {{(APB_DW-POOL_W){1'b0}}, value};
        @(negedge i_clk);
        apb_en <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        apb_sel   <= 1'b0;
        apb_en    <= 1'b0;
        apb_write <= 1'b0;
        pool_cfg  = value;
        free_ptr  = '0;
        slot_busy = '{default: 1'b0};
    endtask

    // one phase at a new pool size; mostly allocates so mid-size pools fill and evict
    task automatic queue_random_phase(input int unsigned size);
        int unsigned n;
        int unsigned count;
        int unsigned alloc_pct;
        int unsigned i;
        t_slot_req   r;
        n         = (size > SLOT_CAP) ? SLOT_CAP : size;
        count     = (size <= 8) ? 20 : ((size <= 300) ? 170 : 50);
        alloc_pct = $urandom_range(70, 90);
        wait_idle();
        write_pool_size(size[POOL_W-1:0]);
        for (i = 0; i < count; i++) begin
            r.idx = IDX_W'($urandom_range(0, SLOT_CAP - 1));
            if ($urandom_range(1, 100) <= alloc_pct) begin
                r.op = OP_ALLOC;
            end else begin
                r.op = OP_RELEASE;
                // most releases hit the pool, the rest may fall outside it
                if (n != 0 && $urandom_range(0, 9) != 0)
                    r.idx = IDX_W'($urandom_range(0, n - 1));
            end
            pending_slot_ops.insert(pending_slot_ops.size(), r);
        end
    endtask

    initial begin : stimulus
        int unsigned p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default pool of 1024: strided grants, releases at both ends
        push_request(OP_ALLOC, 10'h3ff);
        push_request(OP_ALLOC, 10'h000);
        push_request(OP_ALLOC, 10'h155);
        push_request(OP_RELEASE, 10'd8);
        push_request(OP_RELEASE, 10'd1023);
        push_request(OP_RELEASE, 10'd0);
        push_request(OP_ALLOC, 10'h2aa);
        wait_idle();

        // pool of 3: stride wraps, pool fills, scan goes round and evicts
        write_pool_size(11'd3);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_RELEASE, 10'd1);
        push_request(OP_RELEASE, 10'd5);
        push_request(OP_RELEASE, 10'd1023);
        push_request(OP_ALLOC, 10'd0);
        wait_idle();

        // empty pool
        write_pool_size(11'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_RELEASE, 10'd0);
        push_request(OP_RELEASE, 10'd1023);
        wait_idle();

        // oversized pool acts as the full pool
        write_pool_size(11'd2047);
        push_request(OP_ALLOC, 10'd1023);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_RELEASE, 10'd1023);
        push_request(OP_RELEASE, 10'd512);
        wait_idle();

        // pool smaller than the stride
        write_pool_size(11'd5);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);

        for (p = 0; p < $size(PHASE_SIZES); p++)
            queue_random_phase(PHASE_SIZES[p]);
        queue_random_phase($urandom_range(17, 300));

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (slot_errors == 0 && expected_slot_results.size() == 0)
            $display("strided_ring_slot_allocator_tb passed");
        else
            $display("strided_ring_slot_allocator_tb failed");
        $finish;
    end

    // request driver: bursts of items with random gaps, valid held until taken
    always @(negedge i_clk) begin : req_driver
        t_slot_req r;
        if (i_rst_n && (!s_valid || req_fire)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_slot_ops.size() != 0) begin
                r = pending_slot_ops.pop_front();
                s_tuser <= r.op;
                s_tdata <= {{(S_DATA_W-IDX_W){1'b0}}, r.idx};
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    // short gaps mostly, now and then a long one, sometimes none
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                             : $urandom_range(0, 3);
                    burst_left = $urandom_range(1, 48);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink: stall pattern changes from time to time at random, plus long hold-offs
    always @(negedge i_clk) begin : result_sink
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held_once && results_seen >= 400) begin
            // one long hold-off so the block backs up and stalls its input
            held_once = 1'b1;
            hold_left = 300;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 1999) == 0) begin
            hold_left = $urandom_range(40, 200);
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(64, 256);
            end else begin
                mode_left--;
            end
            case (sink_mode)
                SINK_OPEN:   m_ready <= 1'b1;
                SINK_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:     m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // result check, prediction of accepted items and the hang watchdog
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        bit      moved;
        req_fire = 1'b0;
        moved    = 1'b0;
        if (i_rst_n) begin
            // results leave before a new item can produce one, so check first
            if (o_m_tvalid && m_ready) begin
                moved = 1'b1;
                results_seen++;
                seen = o_m_tdata[$bits(t_result)-1:0];
                if (expected_slot_results.size() == 0) begin
                    slot_errors++;
                    $display("%0t: result with none expected, expected nothing, got %0b/%0d/%0b",
                             $time, seen.got_slot, seen.slot, seen.evicted);
                end else begin
                    want = expected_slot_results.pop_front();
                    if (seen.got_slot !== want.got_slot) begin
                        slot_errors++;
                        $display("%0t: got_slot mismatch, expected %0b, got %0b",
                                 $time, want.got_slot, seen.got_slot);
                    end
                    if (seen.slot !== want.slot) begin
                        slot_errors++;
                        $display("%0t: slot mismatch, expected %0d, got %0d",
                                 $time, want.slot, seen.slot);
                    end
                    if (seen.evicted !== want.evicted) begin
                        slot_errors++;
                        $display("%0t: evicted mismatch, expected %0b, got %0b",
                                 $time, want.evicted, seen.evicted);
                    end
                end
            end
            if (s_valid && o_s_tready) begin
                moved    = 1'b1;
                req_fire = 1'b1;
                want     = predict_slot_result(t_op'(s_tuser[0]), s_tdata[IDX_W-1:0]);
                expected_slot_results.insert(expected_slot_results.size(), want);
            end
        end
        if (moved || (apb_sel && apb_en))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("strided_ring_slot_allocator_tb failed");
            $finish;
        end
    end

endmodule
